FILE: design/btbs_pkg.sv
// Shared types, constants and helpers for the branch target buffer scoring block.
`timescale 1ns / 1ps

package btbs_pkg;

	localparam int ADDR_W = 32;
	localparam int CLASS_W = 3;
	localparam int CTR_W = 2;
	localparam int FLAG_W = 4;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CLASS_W-1:0] class_t;
	typedef logic [CTR_W-1:0] ctr_t;

	localparam class_t CLS_BYPASS = 3'd1;
	localparam addr_t PC_STEP = 32'd4;
	localparam addr_t COUNT_MAX = 32'hFFFF_FFFF;

	localparam ctr_t CTR_MIN = 2'd0;
	localparam ctr_t CTR_MAX = 2'd3;
	localparam ctr_t CTR_INIT = 2'd2;
	localparam ctr_t CTR_TAKEN_MIN = 2'd2;

	localparam int FLAG_BACKWARD = 0;
	localparam int FLAG_NOT_TAKEN = 1;
	localparam int FLAG_ON_HIT = 2;
	localparam int FLAG_COUNTER = 3;

	typedef struct packed {
		class_t branch_class;
		addr_t branch_pc;
		addr_t branch_target;
		addr_t actual_next_pc;
	} branch_t;

	typedef struct packed {
		logic table_hit;
		logic was_taken;
		addr_t pred_backward;
		addr_t pred_on_hit;
		addr_t pred_counter;
		logic [FLAG_W-1:0] correct_flags;
		addr_t item_count;
		addr_t backward_hits;
		addr_t not_taken_hits;
		addr_t on_hit_hits;
		addr_t counter_hits;
	} score_t;

	typedef struct packed {
		logic valid;
		ctr_t ctr;
	} state_t;

	typedef struct packed {
		logic en;
		state_t state;
	} upd_t;

	localparam state_t STATE_RESET = '{valid: 1'b0, ctr: CTR_INIT};

	function automatic addr_t sat_inc(input addr_t v);
		return (v == COUNT_MAX) ? v : v + 32'd1;
	endfunction

endpackage

FILE: design/btb_two_bit_predictor_scoring.sv
// Top level: direct-mapped BTB with 2-bit counters scoring four next-pc policies.
`timescale 1ns / 1ps

// Takes one resolved branch record per transaction and returns one score transaction
// per record, in order. It accepts one record per cycle unless score_ready holds the
// output; a record passes the input register, then the index stage, the table read and
// scoring stage and the result register before score_valid rises. The table index is
// (pc >> 2) mod ENTRIES, formed by a reciprocal multiply in the first two stages; the
// table sits in RAM with a registered read, and a one-entry forward path covers a record
// that hits the entry written by the record just ahead of it. After reset the block
// sweeps the valid/counter RAM once, one entry per cycle, so branch_ready stays low
// until every entry has been cleared, before the first transaction.
module btb_two_bit_predictor_scoring #(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              branch_valid,
	output logic              branch_ready,
	input  btbs_pkg::branch_t branch,
	output logic              score_valid,
	input  logic              score_ready,
	output btbs_pkg::score_t  score
);

	import btbs_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	branch_t          branch_s1;
	branch_t          branch_s2;
	branch_t          branch_s3;
	logic [IDX_W-1:0] idx_s2;
	logic [IDX_W-1:0] idx_s3;
	logic             score_valid_q;
	score_t           score_q;
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             fwd_hit_q;
	state_t           fwd_state_q;
	addr_t            fwd_tag_q;

	logic             accept;
	logic             adv_s1;
	logic             adv_s2;
	logic             load_out;
	logic             free_s1;
	logic             free_s2;
	logic             free_s3;
	logic [IDX_W-1:0] rd_addr;
	logic             st_wr_en;
	logic [IDX_W-1:0] st_wr_addr;
	state_t           st_wr_data;
	state_t           state_rd;
	addr_t            tag_rd;
	state_t           entry_state;
	addr_t            entry_tag;
	score_t           result;
	upd_t             upd;

	always_comb begin
		load_out = valid_s3 && (!score_valid_q || score_ready);
		free_s3 = !valid_s3 || load_out;
		adv_s2 = valid_s2 && free_s3;
		free_s2 = !valid_s2 || adv_s2;
		adv_s1 = valid_s1 && free_s2;
		free_s1 = !valid_s1 || adv_s1;
		branch_ready = free_s1 && !clr_busy_q;
		accept = branch_valid && branch_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			score_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s3 <= 1'b1;
			end else if (load_out) begin
				valid_s3 <= 1'b0;
			end
			if (load_out) begin
				score_valid_q <= 1'b1;
			end else if (score_ready) begin
				score_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			branch_s1 <= branch;
		end
		if (adv_s1) begin
			branch_s2 <= branch_s1;
		end
		if (adv_s2) begin
			branch_s3 <= branch_s2;
			idx_s3 <= idx_s2;
		end
		if (load_out) begin
			score_q <= result;
		end
	end

	btbs_index #(
		.ENTRIES(ENTRIES)
	) u_index (
		.clk(clk),
		.en (adv_s1),
		.pc (branch_s1.branch_pc),
		.idx(idx_s2)
	);

	// re-read the held entry while the scoring stage stalls
	assign rd_addr = (valid_s3 && !load_out) ? idx_s3 : idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == LAST_IDX) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st_wr_en = clr_busy_q || upd.en;
		st_wr_addr = clr_busy_q ? clr_idx_q : idx_s3;
		st_wr_data = clr_busy_q ? STATE_RESET : upd.state;
	end

	btbs_ram #(
		.WIDTH($bits(state_t)),
		.DEPTH(ENTRIES)
	) u_state_ram (
		.clk    (clk),
		.wr_en  (st_wr_en),
		.wr_addr(st_wr_addr),
		.wr_data(st_wr_data),
		.rd_addr(rd_addr),
		.rd_data(state_rd)
	);

	btbs_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(ENTRIES)
	) u_tag_ram (
		.clk    (clk),
		.wr_en  (upd.en),
		.wr_addr(idx_s3),
		.wr_data(branch_s3.branch_pc),
		.rd_addr(rd_addr),
		.rd_data(tag_rd)
	);

	// forward the entry written in the same cycle it is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= upd.en && (idx_s3 == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_state_q <= upd.state;
		fwd_tag_q <= branch_s3.branch_pc;
	end

	assign entry_state = fwd_hit_q ? fwd_state_q : state_rd;
	assign entry_tag = fwd_hit_q ? fwd_tag_q : tag_rd;

	btbs_score u_score (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (load_out),
		.branch(branch_s3),
		.tag   (entry_tag),
		.state (entry_state),
		.result(result),
		.upd   (upd)
	);

	assign score_valid = score_valid_q;
	assign score = score_q;

`ifndef ASSERT_OFF
	a_no_update_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !upd.en)
		else $error("table update during clearing sweep");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (score_valid && (score.item_count != 32'd0)))
		else $error("delivered score without item count");

	a_hits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		score_valid |-> ((score.backward_hits <= score.item_count)
			&& (score.not_taken_hits <= score.item_count)
			&& (score.on_hit_hits <= score.item_count)
			&& (score.counter_hits <= score.item_count)))
		else $error("policy hit count exceeds item count");
`endif

endmodule

FILE: design/btbs_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module btbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: design/btbs_index.sv
// Table index unit: (pc >> 2) mod ENTRIES by reciprocal multiply over two stages.
`timescale 1ns / 1ps

module btbs_index #(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       en,
	input  btbs_pkg::addr_t            pc,
	output logic [$clog2(ENTRIES)-1:0] idx
);

	import btbs_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int R_W = IDX_W + 1;
	localparam int X_W = ADDR_W - 2;
	localparam int SHIFT = X_W + IDX_W;
	localparam int PROD_W = X_W + 32;
	localparam logic [63:0] RECIP_WIDE = ((64'd1 << SHIFT) + 64'(ENTRIES) - 64'd1)
		/ 64'(ENTRIES);
	localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
	localparam logic [R_W-1:0] ENT_R = R_W'(ENTRIES);

	logic [X_W-1:0]    word;
	logic [PROD_W-1:0] prod;
	logic [R_W-1:0]    q_lo_s2;
	logic [R_W-1:0]    x_lo_s2;
	logic [R_W-1:0]    qn;
	logic [R_W-1:0]    rem;
	logic [R_W-1:0]    rem_fix;

	assign word = pc[ADDR_W-1:2];
	assign prod = PROD_W'(word) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			q_lo_s2 <= prod[SHIFT +: R_W];
			x_lo_s2 <= word[R_W-1:0];
		end
	end

	assign qn = q_lo_s2 * ENT_R;
	assign rem = x_lo_s2 - qn;
	assign rem_fix = (rem >= ENT_R) ? rem - ENT_R : rem;
	assign idx = rem_fix[IDX_W-1:0];

endmodule

FILE: design/btbs_score.sv
// Prediction, scoring, running counts and table entry update for one branch record.
`timescale 1ns / 1ps

module btbs_score (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  btbs_pkg::branch_t branch,
	input  btbs_pkg::addr_t   tag,
	input  btbs_pkg::state_t  state,
	output btbs_pkg::score_t  result,
	output btbs_pkg::upd_t    upd
);

	import btbs_pkg::*;

	addr_t             total_q;
	addr_t             back_q;
	addr_t             nt_q;
	addr_t             onhit_q;
	addr_t             ctr_hits_q;
	addr_t             total_d;
	addr_t             back_d;
	addr_t             nt_d;
	addr_t             onhit_d;
	addr_t             ctr_hits_d;
	addr_t             seq;
	logic              hit;
	logic              use_tbl;
	logic              taken;
	logic              backward;
	logic              ctr_taken;
	logic              eq_tgt;
	logic              eq_seq;
	logic [FLAG_W-1:0] flags;
	ctr_t              ctr_next;

	always_comb begin
		seq = branch.branch_pc + PC_STEP;
		hit = state.valid && (tag == branch.branch_pc);
		use_tbl = hit && (branch.branch_class != CLS_BYPASS);
		taken = branch.actual_next_pc != seq;
		backward = branch.branch_target < branch.branch_pc;
		ctr_taken = state.ctr >= CTR_TAKEN_MIN;
		eq_tgt = branch.branch_target == branch.actual_next_pc;
		eq_seq = seq == branch.actual_next_pc;

		flags[FLAG_BACKWARD] = (use_tbl && backward) ? eq_tgt : eq_seq;
		flags[FLAG_NOT_TAKEN] = eq_seq;
		flags[FLAG_ON_HIT] = use_tbl ? eq_tgt : eq_seq;
		flags[FLAG_COUNTER] = (use_tbl && ctr_taken) ? eq_tgt : eq_seq;

		total_d = sat_inc(total_q);
		back_d = flags[FLAG_BACKWARD] ? sat_inc(back_q) : back_q;
		nt_d = flags[FLAG_NOT_TAKEN] ? sat_inc(nt_q) : nt_q;
		onhit_d = flags[FLAG_ON_HIT] ? sat_inc(onhit_q) : onhit_q;
		ctr_hits_d = flags[FLAG_COUNTER] ? sat_inc(ctr_hits_q) : ctr_hits_q;
	end

	always_comb begin
		result.table_hit = hit;
		result.was_taken = taken;
		result.pred_backward = (use_tbl && backward) ? branch.branch_target : seq;
		result.pred_on_hit = use_tbl ? branch.branch_target : seq;
		result.pred_counter = (use_tbl && ctr_taken) ? branch.branch_target : seq;
		result.correct_flags = flags;
		result.item_count = total_d;
		result.backward_hits = back_d;
		result.not_taken_hits = nt_d;
		result.on_hit_hits = onhit_d;
		result.counter_hits = ctr_hits_d;
	end

	always_comb begin
		if (!hit) begin
			ctr_next = CTR_INIT;
		end else if (taken) begin
			ctr_next = (state.ctr == CTR_MAX) ? state.ctr : state.ctr + 2'd1;
		end else begin
			ctr_next = (state.ctr == CTR_MIN) ? state.ctr : state.ctr - 2'd1;
		end
		upd.en = en && (branch.branch_class != CLS_BYPASS);
		upd.state.valid = 1'b1;
		upd.state.ctr = ctr_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			back_q <= '0;
			nt_q <= '0;
			onhit_q <= '0;
			ctr_hits_q <= '0;
		end else if (en) begin
			total_q <= total_d;
			back_q <= back_d;
			nt_q <= nt_d;
			onhit_q <= onhit_d;
			ctr_hits_q <= ctr_hits_d;
		end
	end

endmodule
